// ===== design/worley_cell_noise_2d_assert.svh =====
// assertion macros for the worley cell noise block
// included by worley_cell_noise_2d to check its own sequencing
`ifndef WORLEY_CELL_NOISE_2D_ASSERT_SVH
`define WORLEY_CELL_NOISE_2D_ASSERT_SVH

`ifndef SYNTH

// antecedent and consequent in the same cycle
`define WCN_ASSERT_SAME(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// consequent in the cycle after the antecedent
`define WCN_ASSERT_NEXT(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`else

`define WCN_ASSERT_SAME(lbl, clk, rst, ant, cons, msg)
`define WCN_ASSERT_NEXT(lbl, clk, rst, ant, cons, msg)

`endif

`endif

// ===== design/wcn2d_pkg.sv =====
// shared types and constants of the worley cell noise block
// used by worley_cell_noise_2d; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wcn2d_pkg;

  localparam int MAX_CELLS_PER_SIDE = 16;
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS = 16;
  localparam int CELL_BITS = 12;
  localparam int GRID_BITS = 5;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 12;

  localparam int S_TDATA_BITS = 64;
  localparam int M_TDATA_BITS = 24;
  localparam int DIST_BITS = 17;

  localparam logic [DIST_BITS-1:0] ONE_Q16 = 17'h10000;

  localparam logic [GRID_BITS-1:0] CELLS_PER_SIDE_RESET = 5'd4;
  localparam logic [CELL_BITS-1:0] CELL_WIDTH_RESET = 12'd64;
  localparam logic [CELL_BITS-1:0] CELL_HEIGHT_RESET = 12'd64;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CELLS_PER_SIDE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_WIDTH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_HEIGHT = 2'd2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y,
    S_CHECK,
    S_ROW,
    S_READ,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_ACC,
    S_SQRT,
    S_FIN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/wcn2d_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module wcn2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/worley_cell_noise_2d.sv =====
// Tileable 2D Worley noise evaluator. A load transaction writes one Q0.16 feature point into
// the table entry row * cells_per_side + column and is answered with kind 0.
// An evaluate transaction divides the pixel by the cell size, walks the 3x3 neighbour cells with
// wraparound and returns the floor square root of the least squared distance in Q1.16, clamped
// to 1.0. One item is in work at a time; the input is not ready until the result has moved to
// the output register. An evaluate of a pixel off the grid ends after the two divisions.
// The bit-serial divider and square root share one subtractor, and each neighbour cell goes
// through the table read and the shared multiplier.
// depends on wcn2d_pkg, wcn2d_ram and worley_cell_noise_2d_assert.svh
`timescale 1ns / 1ps
`default_nettype none

module worley_cell_noise_2d #(
  parameter int MAX_CELLS_PER_SIDE = wcn2d_pkg::MAX_CELLS_PER_SIDE,
  parameter int FRAC_BITS = wcn2d_pkg::FRAC_BITS
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  // config write channel
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [wcn2d_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [wcn2d_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  // input stream
  input  wire logic                                    s_tvalid,
  output logic                                         s_tready,
  // pixel_x, pixel_y, cell_index, feature_x, feature_y
  input  wire logic [wcn2d_pkg::S_TDATA_BITS-1:0]      s_tdata,
  // action
  input  wire logic                                    s_tuser,
  // output stream
  output logic                                         m_tvalid,
  input  wire logic                                    m_tready,
  // distance, zero padding
  output logic [wcn2d_pkg::M_TDATA_BITS-1:0]           m_tdata,
  // kind, out_of_grid
  output logic [1:0]                                   m_tuser
);

  localparam int CB = wcn2d_pkg::COORD_BITS;
  localparam int WB = wcn2d_pkg::CELL_BITS;
  localparam int DB = wcn2d_pkg::DIST_BITS;
  localparam int TD = MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE;
  localparam int AW = (TD > 1) ? $clog2(TD) : 1;
  localparam int NB = $clog2(MAX_CELLS_PER_SIDE + 1);
  localparam int QW = CB + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);
  localparam int AXW = FRAC_BITS + 1;
  localparam int PW = 2 * AXW;
  localparam int SQW = 2 * FRAC_BITS + 3;
  localparam int RTW = FRAC_BITS + 2;
  localparam int RADW = 2 * RTW;
  localparam int ALU_W = (FRAC_BITS + 5 > CB + 1) ? FRAC_BITS + 5 : CB + 1;
  localparam int EW = FRAC_BITS + 3;
  localparam int SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SHR = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam int FXW = (FRAC_BITS > 16) ? FRAC_BITS : 16;
  localparam int DW = RTW + 16;
  localparam logic signed [EW-1:0] ONE_E = EW'(1) << FRAC_BITS;
  localparam logic [RTW-1:0] ONE_R = RTW'(1) << FRAC_BITS;

  wcn2d_pkg::state_t state, state_next;

  logic [wcn2d_pkg::GRID_BITS-1:0] cells_per_side;
  logic [WB-1:0]       cell_width;
  logic [WB-1:0]       cell_height;

  logic [CB-1:0]       py;
  logic [QW-1:0]       q;
  logic [ALU_W-1:0]    rem;
  logic [CW-1:0]       cnt;
  logic [CB-1:0]       row;
  logic [CB-1:0]       col;
  logic [FRAC_BITS-1:0] offx;
  logic [FRAC_BITS-1:0] offy;
  logic [1:0]          dyi;
  logic [1:0]          dxi;
  logic [AW-1:0]       base;
  logic [AXW-1:0]      ax;
  logic [AXW-1:0]      ay;
  logic [PW-1:0]       sqx;
  logic [PW-1:0]       sqy;
  logic [SQW-1:0]      best;
  logic [RADW-1:0]     rad;
  logic [RTW-1:0]      root;
  logic                pend_kind;
  logic [DB-1:0]       pend_dist;
  logic                pend_oog;
  logic                out_kind;
  logic [DB-1:0]       out_dist;
  logic                out_oog;

  logic                accept;
  logic                out_free;
  logic [NB-1:0]       n_eff;
  logic [WB-1:0]       cw_eff;
  logic [WB-1:0]       ch_eff;
  logic [NB-1:0]       row_n;
  logic [NB-1:0]       col_n;
  logic [NB-1:0]       r_sel;
  logic [NB-1:0]       c_sel;
  logic                outside;
  logic                div_last;
  logic                sqrt_last;

  logic [ALU_W-1:0]    alu_a;
  logic [ALU_W-1:0]    alu_b;
  logic [ALU_W:0]      alu_diff;
  logic                alu_ge;
  logic [ALU_W-1:0]    rem_new;
  logic [QW-1:0]       q_step;

  logic [AXW-1:0]      mul_a;
  logic [AXW-1:0]      mul_b;
  logic [PW-1:0]       mul_p;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [31:0]         ram_rdata;

  logic [FRAC_BITS-1:0] fx;
  logic [FRAC_BITS-1:0] fy;
  logic signed [EW-1:0] dxt;
  logic signed [EW-1:0] dyt;
  logic signed [EW-1:0] ex;
  logic signed [EW-1:0] ey;
  logic [SQW-1:0]      sq;
  logic [SQW-1:0]      best_min;
  logic [RTW-1:0]      dc;
  logic [DW-1:0]       dsh;

  // effective grid and cell sizes
  always_comb begin
    if (cells_per_side == '0) begin
      n_eff = NB'(1);
    end else if (32'(cells_per_side) > MAX_CELLS_PER_SIDE) begin
      n_eff = NB'(MAX_CELLS_PER_SIDE);
    end else begin
      n_eff = NB'(cells_per_side);
    end
    cw_eff = (cell_width == '0) ? WB'(1) : cell_width;
    ch_eff = (cell_height == '0) ? WB'(1) : cell_height;
  end

  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign row_n = NB'(row);
  assign col_n = NB'(col);
  assign outside = (32'(row) >= 32'(n_eff)) || (32'(col) >= 32'(n_eff));
  assign div_last = (cnt == CW'(QW - 1));
  assign sqrt_last = (cnt == CW'(RTW - 1));

  // neighbour row and column with wraparound
  always_comb begin
    case (dyi)
      2'd0: r_sel = (row_n == '0) ? n_eff - NB'(1) : row_n - NB'(1);
      2'd1: r_sel = row_n;
      default: r_sel = (row_n == n_eff - NB'(1)) ? '0 : row_n + NB'(1);
    endcase
    case (dxi)
      2'd0: c_sel = (col_n == '0) ? n_eff - NB'(1) : col_n - NB'(1);
      2'd1: c_sel = col_n;
      default: c_sel = (col_n == n_eff - NB'(1)) ? '0 : col_n + NB'(1);
    endcase
  end

  // shared subtractor: restoring divide and digit-by-digit square root
  always_comb begin
    case (state)
      wcn2d_pkg::S_DIV_X: begin
        alu_a = {rem[ALU_W-2:0], q[QW-1]};
        alu_b = ALU_W'(cw_eff);
      end
      wcn2d_pkg::S_DIV_Y: begin
        alu_a = {rem[ALU_W-2:0], q[QW-1]};
        alu_b = ALU_W'(ch_eff);
      end
      wcn2d_pkg::S_SQRT: begin
        alu_a = {rem[ALU_W-3:0], rad[RADW-1:RADW-2]};
        alu_b = ALU_W'({root, 2'b01});
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
    alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    alu_ge = !alu_diff[ALU_W];
    rem_new = alu_ge ? alu_diff[ALU_W-1:0] : alu_a;
    q_step = {q[QW-2:0], alu_ge};
  end

  // shared multiplier: row base and the two squares
  always_comb begin
    case (state)
      wcn2d_pkg::S_ROW: begin
        mul_a = AXW'(r_sel);
        mul_b = AXW'(n_eff);
      end
      wcn2d_pkg::S_SQX: begin
        mul_a = ax;
        mul_b = ax;
      end
      wcn2d_pkg::S_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // offsets to the neighbour feature point, least squared distance and clamped result
  always_comb begin
    fx = FRAC_BITS'((FXW'(ram_rdata[15:0]) << SHL) >> SHR);
    fy = FRAC_BITS'((FXW'(ram_rdata[31:16]) << SHL) >> SHR);
    case (dxi)
      2'd0: dxt = -ONE_E;
      2'd1: dxt = '0;
      default: dxt = ONE_E;
    endcase
    case (dyi)
      2'd0: dyt = -ONE_E;
      2'd1: dyt = '0;
      default: dyt = ONE_E;
    endcase
    ex = $signed(EW'(fx)) - $signed(EW'(offx)) + dxt;
    ey = $signed(EW'(fy)) - $signed(EW'(offy)) + dyt;
    sq = SQW'(sqx) + SQW'(sqy);
    best_min = (sq < best) ? sq : best;
    dc = (root > ONE_R) ? ONE_R : root;
    dsh = (DW'(dc) << 16) >> FRAC_BITS;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wcn2d_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == wcn2d_pkg::ACT_LOAD) ? wcn2d_pkg::S_DONE
                                                         : wcn2d_pkg::S_DIV_X;
        end
      end
      wcn2d_pkg::S_DIV_X: begin
        if (div_last) state_next = wcn2d_pkg::S_DIV_Y;
      end
      wcn2d_pkg::S_DIV_Y: begin
        if (div_last) state_next = wcn2d_pkg::S_CHECK;
      end
      wcn2d_pkg::S_CHECK: begin
        state_next = outside ? wcn2d_pkg::S_DONE : wcn2d_pkg::S_ROW;
      end
      wcn2d_pkg::S_ROW:  state_next = wcn2d_pkg::S_READ;
      wcn2d_pkg::S_READ: state_next = wcn2d_pkg::S_DIFF;
      wcn2d_pkg::S_DIFF: state_next = wcn2d_pkg::S_SQX;
      wcn2d_pkg::S_SQX:  state_next = wcn2d_pkg::S_SQY;
      wcn2d_pkg::S_SQY:  state_next = wcn2d_pkg::S_ACC;
      wcn2d_pkg::S_ACC: begin
        if (dxi != 2'd2) begin
          state_next = wcn2d_pkg::S_READ;
        end else if (dyi != 2'd2) begin
          state_next = wcn2d_pkg::S_ROW;
        end else begin
          state_next = wcn2d_pkg::S_SQRT;
        end
      end
      wcn2d_pkg::S_SQRT: begin
        if (sqrt_last) state_next = wcn2d_pkg::S_FIN;
      end
      wcn2d_pkg::S_FIN: state_next = wcn2d_pkg::S_DONE;
      wcn2d_pkg::S_DONE: begin
        if (out_free) state_next = wcn2d_pkg::S_IDLE;
      end
      default: state_next = wcn2d_pkg::S_IDLE;
    endcase
  end

  // port and table control
  always_comb begin
    s_tready = (state == wcn2d_pkg::S_IDLE) && !rst;
    cfg_ready = !rst;
    ram_we = accept && (s_tuser == wcn2d_pkg::ACT_LOAD) && (32'(s_tdata[31:24]) < TD);
    ram_waddr = AW'(s_tdata[31:24]);
    ram_raddr = base + AW'(c_sel);
    m_tdata = wcn2d_pkg::M_TDATA_BITS'(out_dist);
    m_tuser = {out_oog, out_kind};
  end

  wcn2d_ram #(
    .WIDTH(32),
    .DEPTH(TD)
  ) u_table (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(s_tdata[63:32]),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wcn2d_pkg::S_IDLE;
      m_tvalid <= 1'b0;
      cells_per_side <= wcn2d_pkg::CELLS_PER_SIDE_RESET;
      cell_width <= wcn2d_pkg::CELL_WIDTH_RESET;
      cell_height <= wcn2d_pkg::CELL_HEIGHT_RESET;
    end else begin
      state <= state_next;
      if (state == wcn2d_pkg::S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wcn2d_pkg::REG_CELLS_PER_SIDE: cells_per_side <= cfg_data[wcn2d_pkg::GRID_BITS-1:0];
          wcn2d_pkg::REG_CELL_WIDTH:     cell_width <= cfg_data[WB-1:0];
          wcn2d_pkg::REG_CELL_HEIGHT:    cell_height <= cfg_data[WB-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      wcn2d_pkg::S_IDLE: begin
        if (accept) begin
          py <= s_tdata[2*CB-1:CB];
          q <= {s_tdata[CB-1:0], {FRAC_BITS{1'b0}}};
          rem <= '0;
          cnt <= '0;
          pend_kind <= wcn2d_pkg::ACT_LOAD;
          pend_dist <= '0;
          pend_oog <= 1'b0;
        end
      end
      wcn2d_pkg::S_DIV_X: begin
        if (div_last) begin
          col <= q_step[QW-1:FRAC_BITS];
          offx <= q_step[FRAC_BITS-1:0];
          q <= {py, {FRAC_BITS{1'b0}}};
          rem <= '0;
          cnt <= '0;
        end else begin
          rem <= rem_new;
          q <= q_step;
          cnt <= cnt + CW'(1);
        end
      end
      wcn2d_pkg::S_DIV_Y: begin
        rem <= rem_new;
        q <= q_step;
        cnt <= cnt + CW'(1);
        if (div_last) begin
          row <= q_step[QW-1:FRAC_BITS];
          offy <= q_step[FRAC_BITS-1:0];
        end
      end
      wcn2d_pkg::S_CHECK: begin
        pend_kind <= wcn2d_pkg::ACT_EVAL;
        pend_dist <= wcn2d_pkg::ONE_Q16;
        pend_oog <= outside;
        dyi <= 2'd0;
        dxi <= 2'd0;
        best <= '1;
      end
      wcn2d_pkg::S_ROW: begin
        base <= AW'(mul_p);
      end
      wcn2d_pkg::S_DIFF: begin
        ax <= AXW'(ex[EW-1] ? -ex : ex);
        ay <= AXW'(ey[EW-1] ? -ey : ey);
      end
      wcn2d_pkg::S_SQX: begin
        sqx <= mul_p;
      end
      wcn2d_pkg::S_SQY: begin
        sqy <= mul_p;
      end
      wcn2d_pkg::S_ACC: begin
        best <= best_min;
        if (dxi != 2'd2) begin
          dxi <= dxi + 2'd1;
        end else begin
          dxi <= 2'd0;
          dyi <= dyi + 2'd1;
        end
        rad <= RADW'(best_min);
        rem <= '0;
        root <= '0;
        cnt <= '0;
      end
      wcn2d_pkg::S_SQRT: begin
        rem <= rem_new;
        root <= {root[RTW-2:0], alu_ge};
        rad <= rad << 2;
        cnt <= cnt + CW'(1);
      end
      wcn2d_pkg::S_FIN: begin
        pend_dist <= DB'(dsh);
      end
      wcn2d_pkg::S_DONE: begin
        if (out_free) begin
          out_kind <= pend_kind;
          out_dist <= pend_dist;
          out_oog <= pend_oog;
        end
      end
      default: ;
    endcase
  end

`include "worley_cell_noise_2d_assert.svh"

  `WCN_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, state != wcn2d_pkg::S_IDLE, "accepted transaction left the sequencer idle")
  `WCN_ASSERT_NEXT(a_taken_clears, clk, rst, m_tvalid && m_tready && state != wcn2d_pkg::S_DONE, !m_tvalid, "taken result still valid")
  `WCN_ASSERT_SAME(a_load_zero, clk, rst, m_tvalid && out_kind == wcn2d_pkg::ACT_LOAD, out_dist == '0 && !out_oog, "load answer carries data")
  `WCN_ASSERT_SAME(a_oog_one, clk, rst, m_tvalid && out_oog, out_dist == wcn2d_pkg::ONE_Q16 && out_kind == wcn2d_pkg::ACT_EVAL, "off-grid answer not 1.0")
  `WCN_ASSERT_SAME(a_dist_clamped, clk, rst, m_tvalid, out_dist <= wcn2d_pkg::ONE_Q16, "distance above 1.0")

endmodule

`default_nettype wire
